// ===== src/assert_macros.svh =====
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define LPHT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define LPHT_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/lpht_pkg.sv =====
// Shared types and codes for the linear probing hash table.
package lpht_pkg;

    typedef logic [1:0] t_action;
    typedef logic [2:0] t_status;

    localparam t_action ACT_INSERT = 2'd0;
    localparam t_action ACT_FIND   = 2'd1;
    localparam t_action ACT_ERASE  = 2'd2;

    localparam t_status ST_INSERTED  = 3'd0;
    localparam t_status ST_UPDATED   = 3'd1;
    localparam t_status ST_FULL      = 3'd2;
    localparam t_status ST_FOUND     = 3'd3;
    localparam t_status ST_NOT_FOUND = 3'd4;
    localparam t_status ST_ERASED    = 3'd5;
    localparam t_status ST_EMPTY_KEY = 3'd6;

    localparam int HASH_W   = 32;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 9;
    localparam int CHAR_W   = 8;
    localparam int RAW_KEY_W = 64;

endpackage

// ===== src/lpht_hash.sv =====
// Character hash h = h*131 + c followed by reduction modulo the table depth.
module lpht_hash #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_CHARS   = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [8*KEY_CHARS-1:0]             i_key,
    output logic                               o_done,
    output logic [$clog2(TABLE_DEPTH)-1:0]     o_home
);
    import lpht_pkg::*;

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int RW   = AW + 1;
    localparam int KW   = 8 * KEY_CHARS;
    localparam int CW   = $clog2(KEY_CHARS + 1);
    localparam int PW   = 2 * HASH_W;
    localparam int QS   = HASH_W - 1 + AW;
    localparam bit POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic [RW-1:0] DV = RW'(TABLE_DEPTH);
    // floor(2^QS / depth), fits 32 bits; quotient estimate is exact or one low
    localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << QS) / TABLE_DEPTH);

    localparam logic [2:0] H_IDLE = 3'd0;
    localparam logic [2:0] H_MIX  = 3'd1;
    localparam logic [2:0] H_MUL  = 3'd2;
    localparam logic [2:0] H_SUB  = 3'd3;
    localparam logic [2:0] H_FIX  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [KW-1:0]     r_key, n_key;
    logic [CW-1:0]     r_left, n_left;
    logic [HASH_W-1:0] r_h, n_h;
    logic [RW-1:0]     r_q, n_q;
    logic [RW-1:0]     r_rem, n_rem;
    logic              r_done, n_done;
    logic [AW-1:0]     r_home, n_home;

    logic [CHAR_W-1:0] c;
    logic [PW-1:0]     prod;
    logic [RW-1:0]     qd;

    assign c = r_key[CHAR_W-1:0];

    // remainder = h - q*depth, only the low RW bits matter since it is below 2*depth
    assign prod = PW'(r_h) * PW'(RECIP);
    assign qd   = r_q * DV;

    always_comb begin
        n_state = r_state;
        n_key   = r_key;
        n_left  = r_left;
        n_h     = r_h;
        n_q     = r_q;
        n_rem   = r_rem;
        n_done  = 1'b0;
        n_home  = r_home;
        unique case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    n_key   = i_key;
                    n_left  = CW'(KEY_CHARS);
                    n_h     = '0;
                    n_state = H_MIX;
                end
            end
            H_MIX: begin
                if (r_left == '0 || c == '0) begin
                    if (POW2) begin
                        n_home  = r_h[AW-1:0];
                        n_done  = 1'b1;
                        n_state = H_IDLE;
                    end else begin
                        n_state = H_MUL;
                    end
                end else begin
                    n_h    = (r_h << 7) + (r_h << 1) + r_h + HASH_W'(c);
                    n_key  = r_key >> CHAR_W;
                    n_left = r_left - 1'b1;
                end
            end
            H_MUL: begin
                n_q     = prod[QS +: RW];
                n_state = H_SUB;
            end
            H_SUB: begin
                n_rem   = r_h[RW-1:0] - qd;
                n_state = H_FIX;
            end
            H_FIX: begin
                n_home  = (r_rem >= DV) ? AW'(r_rem - DV) : r_rem[AW-1:0];
                n_done  = 1'b1;
                n_state = H_IDLE;
            end
            default: n_state = H_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_key  <= n_key;
        r_left <= n_left;
        r_h    <= n_h;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_home <= n_home;
    end

    assign o_done = r_done;
    assign o_home = r_home;

endmodule

// ===== src/lpht_slot_ram.sv =====
// Slot store: one write port, one registered read port.
module lpht_slot_ram #(
    parameter int DEPTH = 256,
    parameter int KW    = 64
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [KW-1:0]             i_wkey,
    input  logic [31:0]               i_wval,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [KW-1:0]             o_rkey,
    output logic [31:0]               o_rval
);
    logic [KW+31:0] mem [DEPTH];
    logic [KW+31:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wkey, i_wval};
        end
        r_rd <= mem[i_raddr];
    end

    assign o_rkey = r_rd[KW+31:32];
    assign o_rval = r_rd[31:0];

endmodule

// ===== src/linear_probe_hash_table.sv =====
// Top level: open addressing hash table with linear probing.
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ------------------------------------
//  in       sink       i_in_valid / o_in_stall   i_action, i_key_chars, i_entry_value
//  out      source     o_out_valid / i_out_stall o_status, o_found_value, o_entry_count
//
// A transaction hashes the key (the hash unit mixes one character per cycle)
// and then probes the table (one slot store read per cycle); when TABLE_DEPTH
// is not a power of two the hash adds a reciprocal multiply, subtract and
// correct step. Empty keys, a full table on insert and unused actions skip
// hashing and probing. After reset the slot store is cleared one entry per
// cycle, with o_in_stall high.
// A finished result waits in the output register, so a new transaction is
// taken while the previous result is still stalled.
module linear_probe_hash_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_CHARS   = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lpht_pkg::t_action    i_action,
    input  logic [63:0]          i_key_chars,
    input  logic [31:0]          i_entry_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lpht_pkg::t_status    o_status,
    output logic [31:0]          o_found_value,
    output logic [8:0]           o_entry_count
);
    import lpht_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int KW    = 8 * KEY_CHARS;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [AW-1:0]    LAST_SLOT = AW'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_DEPTH);

    // control states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]         r_state, n_state;
    t_action            r_action, n_action;
    logic [KW-1:0]      r_key, n_key;
    logic [VALUE_W-1:0] r_val, n_val;
    logic [AW-1:0]      r_pos, n_pos;
    logic [AW-1:0]      r_steps, n_steps;
    logic [CNT_W-1:0]   r_count, n_count;
    t_status            r_res_status, n_res_status;
    logic [VALUE_W-1:0] r_res_fval, n_res_fval;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [VALUE_W-1:0] r_out_fval, n_out_fval;
    logic [CNT_W-1:0]   r_out_count, n_out_count;

    // key normalization
    logic [KW-1:0]      norm_key;
    logic               keep;
    logic               key_zero;
    logic               full;

    // hash unit
    logic               hash_start;
    logic               hash_done;
    logic [AW-1:0]      hash_home;

    // slot store
    logic               we;
    logic [KW-1:0]      wkey;
    logic [VALUE_W-1:0] wval;
    logic [KW-1:0]      rkey;
    logic [VALUE_W-1:0] rval;
    logic [AW-1:0]      pos_inc;

    // Characters after the first zero byte do not belong to the key.
    always_comb begin
        keep = 1'b1;
        for (int j = 0; j < KEY_CHARS; j++) begin
            keep = keep & (i_key_chars[8*j +: 8] != 8'd0);
            norm_key[8*j +: 8] = keep ? i_key_chars[8*j +: 8] : 8'd0;
        end
    end

    assign key_zero = (norm_key == '0);
    assign full     = (r_count == FULL_CNT);
    assign pos_inc  = (r_pos == LAST_SLOT) ? '0 : r_pos + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_key        = r_key;
        n_val        = r_val;
        n_pos        = r_pos;
        n_steps      = r_steps;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_fval   = r_res_fval;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_fval   = r_out_fval;
        n_out_count  = r_out_count;
        hash_start   = 1'b0;
        we           = 1'b0;
        wkey         = r_key;
        wval         = r_val;

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                // sweep zeros through the slot store after reset
                we    = 1'b1;
                wkey  = '0;
                wval  = '0;
                n_pos = pos_inc;
                if (r_pos == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action   = i_action;
                    n_key      = norm_key;
                    n_val      = i_entry_value;
                    n_res_fval = '0;
                    if (key_zero) begin
                        n_res_status = ST_EMPTY_KEY;
                        n_state      = S_DONE;
                    end else begin
                        case (i_action) inside
                            ACT_INSERT: begin
                                if (full) begin
                                    n_res_status = ST_FULL;
                                    n_state      = S_DONE;
                                end else begin
                                    hash_start = 1'b1;
                                    n_state    = S_HASH;
                                end
                            end
                            ACT_FIND, ACT_ERASE: begin
                                hash_start = 1'b1;
                                n_state    = S_HASH;
                            end
                            default: begin
                                n_res_status = ST_NOT_FOUND;
                                n_state      = S_DONE;
                            end
                        endcase
                    end
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_pos   = hash_home;   // issues the home slot read
                    n_steps = '0;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // rkey/rval hold slot r_pos
                if (rkey == '0) begin
                    n_state = S_DONE;
                    if (r_action == ACT_INSERT) begin
                        we           = 1'b1;
                        n_count      = r_count + 1'b1;
                        n_res_status = ST_INSERTED;
                    end else begin
                        n_res_status = ST_NOT_FOUND;
                    end
                end else if (rkey == r_key) begin
                    n_state = S_DONE;
                    unique case (r_action)
                        ACT_INSERT: begin
                            we           = 1'b1;
                            n_res_status = ST_UPDATED;
                        end
                        ACT_FIND: begin
                            n_res_fval   = rval;
                            n_res_status = ST_FOUND;
                        end
                        default: begin
                            we           = 1'b1;
                            wkey         = '0;
                            wval         = '0;
                            n_count      = r_count - 1'b1;
                            n_res_status = ST_ERASED;
                        end
                    endcase
                end else if (r_steps == LAST_SLOT) begin
                    // every slot visited
                    n_state      = S_DONE;
                    n_res_status = (r_action == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
                end else begin
                    n_pos   = pos_inc;
                    n_steps = r_steps + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_fval   = r_res_fval;
                    n_out_count  = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pos       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_action     <= n_action;
        r_key        <= n_key;
        r_val        <= n_val;
        r_steps      <= n_steps;
        r_res_status <= n_res_status;
        r_res_fval   <= n_res_fval;
        r_out_status <= n_out_status;
        r_out_fval   <= n_out_fval;
        r_out_count  <= n_out_count;
    end

    lpht_hash #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_CHARS   (KEY_CHARS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (norm_key),
        .o_done  (hash_done),
        .o_home  (hash_home)
    );

    // read address is the next probe position, so data lines up with r_pos
    lpht_slot_ram #(
        .DEPTH (TABLE_DEPTH),
        .KW    (KW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_pos),
        .i_wkey  (wkey),
        .i_wval  (wval),
        .i_raddr (n_pos),
        .o_rkey  (rkey),
        .o_rval  (rval)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_value = r_out_fval;
    assign o_entry_count = COUNT_W'(r_out_count);

endmodule

// ===== src/lpht_checker.sv =====
// Port-level checker for the hash table, bound to the top level.
`include "assert_macros.svh"

module lpht_checker #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_in_stall,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  lpht_pkg::t_status  o_status,
    input  logic [31:0]        o_found_value,
    input  logic [8:0]         o_entry_count
);
    import lpht_pkg::*;

    // stalled result holds
    `LPHT_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) && $stable(o_found_value) && $stable(o_entry_count), "stalled result changed")

    // only a successful find returns a value
    `LPHT_ASSERT(a_fval_zero, o_out_valid && o_status != ST_FOUND |-> o_found_value == 32'd0, "value on non-find result")

    // count stays within the table
    `LPHT_ASSERT(a_count_max, o_out_valid |-> o_entry_count <= TABLE_DEPTH, "entry count above depth")

    // no code beyond the empty-key status
    `LPHT_ASSERT(a_status_max, o_out_valid |-> o_status <= ST_EMPTY_KEY, "bad status code")

    // clearing pass starts right after reset
    `LPHT_ASSERT_ALWAYS(a_clear_stall, !i_rst_n |=> o_in_stall, "input open during clear")

endmodule

bind linear_probe_hash_table lpht_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_lpht_checker (.*);
